// ----- design/pid_controller_antiwindup_defines.svh -----
// Assertion macros shared by the PID controller modules
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// Check a same-cycle implication outside reset
`define PID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pid_aw_pkg.sv -----
// Types, constants and codes of the PID controller
`timescale 1ns / 1ps
package pid_aw_pkg;

   // Field and datapath widths
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int ACC_W     = 40;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CMD_W     = 2;
   localparam int ERR_W     = DATA_W + 1;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = 16;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int RES_W     = PROD_W + 1;
   localparam int P_W       = 2 * DATA_W + 1;
   localparam int WIDE_W    = 52;
   localparam int DIV_STEPS = PROD_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

   // Reset values
   localparam logic [CFG_W-1:0]         KP_RESET      = 16'd256;
   localparam logic [CFG_W-1:0]         TI_RESET      = 16'd1000;
   localparam logic [CFG_W-1:0]         TD_RESET      = 16'd0;
   localparam logic signed [DATA_W-1:0] LOW_RESET     = 16'sd0;
   localparam logic signed [DATA_W-1:0] HIGH_RESET    = 16'sd255;
   localparam logic [CFG_W-1:0]         SP_RESET      = 16'd100;
   localparam logic [CFG_W-1:0]         ELAPSED_RESET = 16'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_MANUAL = 2'd1,
      CMD_AUTO   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_KP     = 3'd0,
      CSR_TI          = 3'd1,
      CSR_TD          = 3'd2,
      CSR_LIMIT_LOW   = 3'd3,
      CSR_LIMIT_HIGH  = 3'd4,
      CSR_SAMPLE_PER  = 3'd5,
      CSR_FORWARD     = 3'd6
   } csr_idx_type;

   typedef enum logic {
      MDU_MUL = 1'b0,
      MDU_DIV = 1'b1
   } mdu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P_GO,
      ST_P_WAIT,
      ST_BUMP,
      ST_PDT_GO,
      ST_PDT_WAIT,
      ST_DIVI_GO,
      ST_DIVI_WAIT,
      ST_WINDUP,
      ST_GT_GO,
      ST_GT_WAIT,
      ST_GTM_GO,
      ST_GTM_WAIT,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_SUM,
      ST_DONE
   } core_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] measurement;
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] manual_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     updated;
      logic                     auto_mode;
      logic signed [ACC_W-1:0]  integral_value;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0]         gain_kp;
      logic [CFG_W-1:0]         integral_time_ms;
      logic [CFG_W-1:0]         derivative_time_ms;
      logic signed [DATA_W-1:0] limit_low;
      logic signed [DATA_W-1:0] limit_high;
      logic [CFG_W-1:0]         sample_period_ms;
      logic                     forward_acting;
   } cfg_type;

   typedef struct packed {
      logic               start;
      mdu_op_type         op;
      logic               neg;
      logic [PROD_W-1:0]  a;
      logic [MUL_B_W-1:0] b;
   } mdu_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [RES_W-1:0] result;
   } mdu_rsp_type;

endpackage

// ----- design/pid_controller_antiwindup.sv -----
// PID controller with clamping anti-windup: configuration registers and unit wiring
//
// Input channel req_*: one item carries a command (tick, go manual, go auto) with
// the measurement, target and manual value. Result channel rsp_*: exactly one item
// per input item, with the drive, an update flag, the mode and the integral.
// Configuration: csr_write_en, csr_index, csr_wdata write one register per cycle;
// write only while no item is in flight. Limit writes that would leave
// low >= high and a zero sample period are dropped.
// An item that updates runs the shared multiply/divide unit through four multiplies
// and two 48-bit divisions at two quotient bits a cycle (one division fewer with
// the integral time at zero); going auto uses one multiply, a plain tick or a manual
// command none. The block takes one item at a time and is ready again the cycle
// after its result is registered.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only its own result stalls until rsp_ready takes the first.
// Reset (synchronous) loads the default gains and limits, auto mode, a zero
// integral and drive, and an elapsed count of 100 ms.
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_defines.svh"
module pid_controller_antiwindup import pid_aw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type                  cfg_ff, cfg_in;
   logic signed [DATA_W-1:0] wdata_s;
   mdu_req_type              mdu_req;
   mdu_rsp_type              mdu_rsp;

   assign wdata_s = signed'(csr_wdata[DATA_W-1:0]);

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_GAIN_KP:    cfg_in.gain_kp            = csr_wdata;
            CSR_TI:         cfg_in.integral_time_ms   = csr_wdata;
            CSR_TD:         cfg_in.derivative_time_ms = csr_wdata;
            CSR_LIMIT_LOW: begin
               if (wdata_s < cfg_ff.limit_high) begin
                  cfg_in.limit_low = wdata_s;
               end
            end
            CSR_LIMIT_HIGH: begin
               if (wdata_s > cfg_ff.limit_low) begin
                  cfg_in.limit_high = wdata_s;
               end
            end
            CSR_SAMPLE_PER: begin
               if (csr_wdata != '0) begin
                  cfg_in.sample_period_ms = csr_wdata;
               end
            end
            CSR_FORWARD:    cfg_in.forward_acting = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_kp            <= KP_RESET;
         cfg_ff.integral_time_ms   <= TI_RESET;
         cfg_ff.derivative_time_ms <= TD_RESET;
         cfg_ff.limit_low          <= LOW_RESET;
         cfg_ff.limit_high         <= HIGH_RESET;
         cfg_ff.sample_period_ms   <= SP_RESET;
         cfg_ff.forward_acting     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pid_aw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mdu_req   (mdu_req),
      .mdu_rsp   (mdu_rsp)
   );

   pid_aw_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   `PID_ASSERT_NOW(limits_ordered, clock, reset, 1'b1, cfg_ff.limit_low < cfg_ff.limit_high, "output limits out of order")

endmodule

// ----- design/pid_aw_mdu.sv -----
// Shared multiply and divide unit: registered 32x16 multiply, two-bit-a-cycle divide
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_defines.svh"
module pid_aw_mdu import pid_aw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mdu_req_type req,
   output mdu_rsp_type rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]       quo_ff, quo_in;
   logic [MUL_B_W-1:0]      rem_ff, rem_in;
   logic [MUL_B_W-1:0]      dvs_ff, dvs_in;
   logic                    neg_ff, neg_in;
   logic signed [RES_W-1:0] res_ff, res_in;
   logic [PROD_W-1:0]       prod;
   logic [MUL_B_W:0]        step1, step2;

   // One restoring division step: {quotient bit, new remainder}
   function automatic logic [MUL_B_W:0] div_step(input logic [MUL_B_W-1:0] r,
                                                 input logic b,
                                                 input logic [MUL_B_W-1:0] d);
      logic [MUL_B_W:0] trial;
      logic [MUL_B_W:0] diff;
      trial = {r, b};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         div_step = {1'b1, diff[MUL_B_W-1:0]};
      end else begin
         div_step = {1'b0, trial[MUL_B_W-1:0]};
      end
   endfunction

   // Attach the sign to a magnitude
   function automatic logic signed [RES_W-1:0] apply_sign(input logic [PROD_W-1:0] m,
                                                         input logic neg);
      logic signed [RES_W-1:0] v;
      v = signed'({1'b0, m});
      apply_sign = neg ? -v : v;
   endfunction

   assign prod  = PROD_W'(req.a[MUL_A_W-1:0]) * PROD_W'(req.b);
   assign step1 = div_step(rem_ff, quo_ff[PROD_W-1], dvs_ff);
   assign step2 = div_step(step1[MUL_B_W-1:0], quo_ff[PROD_W-2], dvs_ff);

   // Start an operation or advance the division
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (req.start) begin
         if (req.op == MDU_MUL) begin
            res_in  = apply_sign(prod, req.neg);
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            quo_in  = req.a;
            rem_in  = '0;
            dvs_in  = req.b;
            neg_in  = req.neg;
         end
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-3:0], step1[MUL_B_W], step2[MUL_B_W]};
         rem_in = step2[MUL_B_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = apply_sign(quo_in, neg_ff);
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold operands and result
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

   `PID_ASSERT_NOW(no_start_while_busy, clock, reset, req.start, !busy_ff, "mdu started while dividing")

endmodule

// ----- design/pid_aw_core.sv -----
// Sequencer and controller state: drives the shared unit through one PID update
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_defines.svh"
module pid_aw_core import pid_aw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   output mdu_req_type  mdu_req,
   input  mdu_rsp_type  mdu_rsp
);

   localparam logic signed [WIDE_W-1:0] AccMax =
      {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] AccMin =
      {{(WIDE_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

   core_state_type           state_ff, state_in;
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic signed [ERR_W-1:0]  dm_ff, dm_in;
   logic signed [DATA_W-1:0] meas_ff, meas_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [WIDE_W-1:0] sum_ff, sum_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic [CFG_W-1:0]         elapsed_ff, elapsed_in;
   logic                     auto_ff, auto_in;
   logic signed [DATA_W-1:0] held_ff, held_in;
   logic                     upd_ff, upd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_data_ff, rsp_data_in;

   logic signed [ERR_W-1:0]  gain_s;
   logic [MUL_B_W-1:0]       mag_e, mag_g, mag_dm;
   logic signed [P_W-1:0]    p_abs;
   logic signed [RES_W-1:0]  res_abs;
   logic [PROD_W-1:0]        mag_res;
   logic                     res_neg;
   logic signed [WIDE_W-1:0] hq, lq, p_w, acc_w, res_w, tot, sum_clamped, sum_round;
   logic signed [DATA_W-1:0] held_clamped;
   logic [CFG_W-1:0]         elapsed_inc;

   // Saturate a wide value to the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
      if (x > AccMax) begin
         sat_acc = AccMax[ACC_W-1:0];
      end else if (x < AccMin) begin
         sat_acc = AccMin[ACC_W-1:0];
      end else begin
         sat_acc = x[ACC_W-1:0];
      end
   endfunction

   // Magnitude of a 17-bit signed value; at most 16 bits for these operands
   function automatic logic [MUL_B_W-1:0] mag17(input logic signed [ERR_W-1:0] x);
      logic signed [ERR_W-1:0] n;
      n = x[ERR_W-1] ? -x : x;
      mag17 = n[MUL_B_W-1:0];
   endfunction

   // Operand shaping for the shared unit
   assign gain_s  = cfg.forward_acting ? signed'({1'b0, cfg.gain_kp})
                                       : -signed'({1'b0, cfg.gain_kp});
   assign mag_e   = mag17(e_ff);
   assign mag_g   = mag17(gain_s);
   assign mag_dm  = mag17(dm_ff);
   assign p_abs   = p_ff[P_W-1] ? -p_ff : p_ff;
   assign res_neg = mdu_rsp.result[RES_W-1];
   assign res_abs = res_neg ? -mdu_rsp.result : mdu_rsp.result;
   assign mag_res = res_abs[PROD_W-1:0];

   // Wide views of the terms in Q.8
   assign hq    = WIDE_W'(cfg.limit_high) <<< FRAC_BITS;
   assign lq    = WIDE_W'(cfg.limit_low) <<< FRAC_BITS;
   assign p_w   = WIDE_W'(p_ff);
   assign acc_w = WIDE_W'(acc_ff);
   assign res_w = WIDE_W'(mdu_rsp.result);
   assign tot   = acc_w + p_w;

   // Clamp the output sum, then round to nearest with ties up; the result stays in limits
   assign sum_clamped = (sum_ff > hq) ? hq : ((sum_ff < lq) ? lq : sum_ff);
   assign sum_round   = (sum_clamped + WIDE_W'(HALF_Q)) >>> FRAC_BITS;

   assign held_clamped = (held_ff < cfg.limit_low)  ? cfg.limit_low :
                         (held_ff > cfg.limit_high) ? cfg.limit_high : held_ff;
   assign elapsed_inc  = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      dm_in        = dm_ff;
      meas_in      = meas_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      elapsed_in   = elapsed_ff;
      auto_in      = auto_ff;
      held_in      = held_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mdu_req.start = 1'b0;
      mdu_req.op    = MDU_MUL;
      mdu_req.neg   = 1'b0;
      mdu_req.a     = '0;
      mdu_req.b     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               e_in    = ERR_W'(req_data.target) - ERR_W'(req_data.measurement);
               dm_in   = ERR_W'(req_data.measurement) - ERR_W'(prev_ff);
               meas_in = req_data.measurement;
               upd_in  = 1'b0;
               state_in = ST_DONE;
               case (cmd_type'(req_data.command))
                  CMD_TICK: begin
                     elapsed_in = elapsed_inc;
                     if (auto_ff && (elapsed_inc >= cfg.sample_period_ms)) begin
                        upd_in   = 1'b1;
                        state_in = ST_P_GO;
                     end
                  end
                  CMD_MANUAL: begin
                     auto_in = 1'b0;
                     held_in = req_data.manual_value;
                  end
                  CMD_AUTO: begin
                     if (!auto_ff) begin
                        state_in = ST_P_GO;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // Proportional term: error times signed gain
         ST_P_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_MUL;
            mdu_req.a     = PROD_W'(mag_e);
            mdu_req.b     = mag_g;
            mdu_req.neg   = e_ff[ERR_W-1] ^ gain_s[ERR_W-1];
            state_in      = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (mdu_rsp.done) begin
               p_in     = mdu_rsp.result[P_W-1:0];
               state_in = upd_ff ? ST_PDT_GO : ST_BUMP;
            end
         end
         // Bumpless entry to auto: preload the integral
         ST_BUMP: begin
            acc_in   = sat_acc((WIDE_W'(held_clamped) <<< FRAC_BITS) - p_w);
            prev_in  = meas_ff;
            auto_in  = 1'b1;
            state_in = ST_DONE;
         end
         // Integral increment: P * dt / Ti
         ST_PDT_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_MUL;
            mdu_req.a     = PROD_W'(p_abs[MUL_A_W-1:0]);
            mdu_req.b     = elapsed_ff;
            mdu_req.neg   = p_ff[P_W-1];
            state_in      = ST_PDT_WAIT;
         end
         ST_PDT_WAIT: begin
            if (mdu_rsp.done) begin
               state_in = (cfg.integral_time_ms != '0) ? ST_DIVI_GO : ST_WINDUP;
            end
         end
         ST_DIVI_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_DIV;
            mdu_req.a     = mag_res;
            mdu_req.b     = cfg.integral_time_ms;
            mdu_req.neg   = res_neg;
            state_in      = ST_DIVI_WAIT;
         end
         ST_DIVI_WAIT: begin
            if (mdu_rsp.done) begin
               acc_in   = sat_acc(acc_w + res_w);
               state_in = ST_WINDUP;
            end
         end
         // Pull the integral back so that P + I stays within the limits
         ST_WINDUP: begin
            if (tot > hq) begin
               acc_in = sat_acc(hq - p_w);
            end else if (tot < lq) begin
               acc_in = sat_acc(lq - p_w);
            end
            state_in = ST_GT_GO;
         end
         // Derivative on measurement: Kp * Td * dmeas / dt
         ST_GT_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_MUL;
            mdu_req.a     = PROD_W'(mag_g);
            mdu_req.b     = cfg.derivative_time_ms;
            mdu_req.neg   = gain_s[ERR_W-1];
            state_in      = ST_GT_WAIT;
         end
         ST_GT_WAIT: begin
            if (mdu_rsp.done) begin
               state_in = ST_GTM_GO;
            end
         end
         ST_GTM_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_MUL;
            mdu_req.a     = mag_res;
            mdu_req.b     = mag_dm;
            mdu_req.neg   = res_neg ^ dm_ff[ERR_W-1];
            state_in      = ST_GTM_WAIT;
         end
         ST_GTM_WAIT: begin
            if (mdu_rsp.done) begin
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            mdu_req.start = 1'b1;
            mdu_req.op    = MDU_DIV;
            mdu_req.a     = mag_res;
            mdu_req.b     = elapsed_ff;
            mdu_req.neg   = res_neg;
            state_in      = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            if (mdu_rsp.done) begin
               sum_in   = p_w + acc_w - res_w;
               state_in = ST_SUM;
            end
         end
         // Clamp, round and commit the new drive
         ST_SUM: begin
            held_in    = sum_round[DATA_W-1:0];
            prev_in    = meas_ff;
            elapsed_in = '0;
            state_in   = ST_DONE;
         end
         // Hand the item to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.drive          = held_ff;
               rsp_data_in.updated        = upd_ff;
               rsp_data_in.auto_mode      = auto_ff;
               rsp_data_in.integral_value = acc_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         prev_ff      <= '0;
         elapsed_ff   <= ELAPSED_RESET;
         auto_ff      <= 1'b1;
         held_ff      <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
         elapsed_ff   <= elapsed_in;
         auto_ff      <= auto_in;
         held_ff      <= held_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold item operands and the output payload
   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      dm_ff       <= dm_in;
      meas_ff     <= meas_in;
      p_ff        <= p_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PID_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted an item without leaving idle")
   `PID_ASSERT_NOW(mdu_done_when_waiting, clock, reset, mdu_rsp.done, state_ff == ST_P_WAIT || state_ff == ST_PDT_WAIT || state_ff == ST_DIVI_WAIT || state_ff == ST_GT_WAIT || state_ff == ST_GTM_WAIT || state_ff == ST_DIVD_WAIT, "unit result arrived outside a wait state")
   `PID_ASSERT_NOW(update_clears_elapsed, clock, reset, state_ff == ST_DONE && upd_ff, elapsed_ff == '0, "elapsed count not cleared by update")
   `PID_ASSERT_NOW(drive_within_limits, clock, reset, state_ff == ST_DONE && upd_ff, held_ff >= cfg.limit_low && held_ff <= cfg.limit_high, "updated drive outside limits")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the PID controller with clamping anti-windup
`timescale 1ns / 1ps
module testbench;
   import pid_aw_pkg::*;

   // Command code that the package leaves unnamed; the block must ignore it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] VMIN = 16'h8000;
   localparam logic signed [DATA_W-1:0] VMAX = 16'h7fff;
   localparam longint MAG_CAP = 64'sd1 <<< 60;
   localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
   localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -(64'sd1 <<< (ACC_W - 1));
   localparam int COUNT_MAX = 65535;
   localparam int MAX_WAIT = 18;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 125;
   localparam int PROBE_ROWS = 24;
   localparam int WIDE_START = 9;
   localparam int NARROW_START = 22;
   localparam int DRAIN_CYCLES = 80;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] measurement;
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] manual_value;
      logic                     fixed;
      rsp_item_type             want;
   } probe_row_type;

   // Directed rows; the first nine run at reset settings with results typed in
   localparam probe_row_type PROBE [PROBE_ROWS] = '{
      '{CMD_TICK,   16'sd0,   16'sd0,    16'sd0,   1'b1, '{16'sd0, 1'b1, 1'b1, 40'sd0}},
      '{CMD_TICK,   16'sd0,   16'sd0,    16'sd0,   1'b1, '{16'sd0, 1'b0, 1'b1, 40'sd0}},
      '{CMD_MANUAL, 16'sd0,   16'sd0,    VMIN,     1'b1, '{VMIN, 1'b0, 1'b0, 40'sd0}},
      '{CMD_MANUAL, VMIN,     VMAX,      VMAX,     1'b1, '{VMAX, 1'b0, 1'b0, 40'sd0}},
      '{CMD_TICK,   16'sd7,   16'sd3,    16'sd0,   1'b1, '{VMAX, 1'b0, 1'b0, 40'sd0}},
      '{CMD_AUTO,   16'sd100, 16'sd100,  VMIN,     1'b1, '{VMAX, 1'b0, 1'b1, 40'sd65280}},
      '{CMD_UNUSED, VMAX,     VMIN,      VMIN,     1'b1, '{VMAX, 1'b0, 1'b1, 40'sd65280}},
      '{CMD_AUTO,   16'sd5,   16'sd9000, 16'sd0,   1'b1, '{VMAX, 1'b0, 1'b1, 40'sd65280}},
      '{CMD_TICK,   16'sd0,   16'sd0,    16'sd0,   1'b1, '{VMAX, 1'b0, 1'b1, 40'sd65280}},
      '{CMD_TICK,   VMIN,     VMAX,      16'sd0,   1'b0, '0},
      '{CMD_TICK,   VMAX,     VMIN,      16'sd0,   1'b0, '0},
      '{CMD_TICK,   VMAX,     VMAX,      16'sd0,   1'b0, '0},
      '{CMD_TICK,   VMIN,     VMIN,      16'sd0,   1'b0, '0},
      '{CMD_MANUAL, 16'sd0,   16'sd0,    VMIN,     1'b0, '0},
      '{CMD_TICK,   16'sd0,   16'sd0,    16'sd0,   1'b0, '0},
      '{CMD_AUTO,   VMIN,     VMAX,      VMAX,     1'b0, '0},
      '{CMD_TICK,   16'sd0,   -16'sd1,   16'sd0,   1'b0, '0},
      '{CMD_UNUSED, -16'sd1,  -16'sd1,   -16'sd1,  1'b0, '0},
      '{CMD_TICK,   -16'sd1,  16'sd0,    16'sd0,   1'b0, '0},
      '{CMD_MANUAL, 16'sd0,   16'sd0,    VMAX,     1'b0, '0},
      '{CMD_AUTO,   VMAX,     VMIN,      16'sd0,   1'b0, '0},
      '{CMD_TICK,   16'sd1234, -16'sd4321, 16'sd0, 1'b0, '0},
      '{CMD_TICK,   16'sd0,   16'sd300,  16'sd0,   1'b0, '0},
      '{CMD_TICK,   16'sd300, 16'sd0,    16'sd0,   1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Typed-in result that travels with the item on offer
   logic want_fixed = 1'b0;
   rsp_item_type want_row = '0;

   // Controller shadow: settings and state as the block should hold them
   cfg_type shadow_cfg = '{KP_RESET, TI_RESET, TD_RESET, LOW_RESET, HIGH_RESET,
                           SP_RESET, 1'b1};
   longint model_integral = 0;
   longint model_prev_meas = 0;
   longint model_held = 0;
   int model_elapsed = int'(ELAPSED_RESET);
   logic model_auto = 1'b1;

   rsp_item_type outputs_due [$];
   int fault_count = 0;
   logic sender_hurry = 1'b0;
   logic receiver_hurry = 1'b0;
   int rx_hold = 0;
   logic signed [DATA_W-1:0] phase_target = '0;

   pid_controller_antiwindup uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic longint acc_sat(longint x);
      return clip(x, ACC_MIN, ACC_MAX);
   endfunction

   // Signed product with operands and magnitude capped at 2^60
   function automatic longint cap_mul(longint a, longint b);
      longint unsigned ua, ub, mag;
      logic flip;
      a = clip(a, -MAG_CAP, MAG_CAP);
      b = clip(b, -MAG_CAP, MAG_CAP);
      flip = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      if (ua != 0 && ub > MAG_CAP / ua) mag = MAG_CAP;
      else mag = ua * ub;
      if (mag > MAG_CAP) mag = MAG_CAP;
      return flip ? -longint'(mag) : longint'(mag);
   endfunction

   // Advance the controller shadow by one item and form the result it reports
   task automatic forecast_item(input req_item_type it, output rsp_item_type res);
      longint meas, tgt, g, p, dt, lo, hi, lq, hq, d, total;
      logic stepped;
      meas = $signed(it.measurement);
      tgt = $signed(it.target);
      g = shadow_cfg.forward_acting ? longint'(shadow_cfg.gain_kp)
                                    : -longint'(shadow_cfg.gain_kp);
      lo = $signed(shadow_cfg.limit_low);
      hi = $signed(shadow_cfg.limit_high);
      lq = lo * ONE_Q;
      hq = hi * ONE_Q;
      stepped = 1'b0;
      case (it.command)
         CMD_TICK: begin
            if (model_elapsed < COUNT_MAX) model_elapsed++;
            if (model_auto && model_elapsed >= int'(shadow_cfg.sample_period_ms)) begin
               dt = model_elapsed;
               p = cap_mul(tgt - meas, g);
               if (shadow_cfg.integral_time_ms != 0)
                  model_integral = acc_sat(model_integral + cap_mul(p, dt)
                                           / longint'(shadow_cfg.integral_time_ms));
               // pull the integral back so that P+I stays inside the limits
               if (model_integral + p > hq) model_integral = acc_sat(hq - p);
               else if (model_integral + p < lq) model_integral = acc_sat(lq - p);
               d = -(cap_mul(cap_mul(g, longint'(shadow_cfg.derivative_time_ms)),
                             meas - model_prev_meas) / dt);
               total = clip(p + model_integral + d, lq, hq);
               model_held = clip((total + (ONE_Q >>> 1)) >>> FRAC_BITS, lo, hi);
               model_prev_meas = meas;
               model_elapsed = 0;
               stepped = 1'b1;
            end
         end
         CMD_MANUAL: begin
            model_auto = 1'b0;
            model_held = $signed(it.manual_value);
         end
         CMD_AUTO: begin
            // bumpless: preload the integral so the next update starts at the held drive
            if (!model_auto) begin
               p = cap_mul(tgt - meas, g);
               model_integral = acc_sat(clip(model_held, lo, hi) * ONE_Q - p);
               model_prev_meas = meas;
               model_auto = 1'b1;
            end
         end
         default: ;
      endcase
      res.drive = model_held[DATA_W-1:0];
      res.updated = stepped;
      res.auto_mode = model_auto;
      res.integral_value = model_integral[ACC_W-1:0];
   endtask

   // Drive one register write at this falling edge and mirror it in the shadow
   task automatic write_register(input csr_idx_type idx, input logic [CFG_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GAIN_KP:    shadow_cfg.gain_kp = val;
         CSR_TI:         shadow_cfg.integral_time_ms = val;
         CSR_TD:         shadow_cfg.derivative_time_ms = val;
         CSR_LIMIT_LOW:  if ($signed(val) < shadow_cfg.limit_high) shadow_cfg.limit_low = val;
         CSR_LIMIT_HIGH: if ($signed(val) > shadow_cfg.limit_low) shadow_cfg.limit_high = val;
         CSR_SAMPLE_PER: if (val != 0) shadow_cfg.sample_period_ms = val;
         CSR_FORWARD:    shadow_cfg.forward_acting = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic offer_item(input req_item_type it, input logic fixed,
                             input rsp_item_type want);
      int gap;
      gap = sender_hurry ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      want_fixed <= fixed;
      want_row <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0, 1: return DATA_W'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: return VMIN;
               1: return VMAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return DATA_W'(int'($urandom_range(0, 800)) - 400);
      endcase
   endfunction

   // Mostly ticks around a steady setpoint, with mode changes and noise mixed in
   function automatic req_item_type random_item();
      req_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78) it.command = CMD_TICK;
      else if (pick < 88) it.command = CMD_MANUAL;
      else if (pick < 97) it.command = CMD_AUTO;
      else it.command = CMD_UNUSED;
      if ($urandom_range(0, 2) == 0) it.measurement = pick_level();
      else it.measurement = phase_target + DATA_W'(int'($urandom_range(0, 64)) - 32);
      it.target = ($urandom_range(0, 9) == 0) ? pick_level() : phase_target;
      it.manual_value = pick_level();
      return it;
   endfunction

   task automatic log_fault(input string what, input rsp_item_type want,
                            input rsp_item_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t %s: drive %0d/%0d updated %0b/%0b auto %0b/%0b integral %0d/%0d",
                  $time, what, want.drive, got.drive, want.updated, got.updated,
                  want.auto_mode, got.auto_mode, want.integral_value, got.integral_value);
   endtask

   // Check each result against the oldest expectation, then queue new ones
   always @(posedge clock) begin : monitor
      rsp_item_type want, predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (outputs_due.size() == 0) begin
               log_fault("unexpected result (expected/actual)", '0, rsp_data);
            end else begin
               want = outputs_due.pop_front();
               if (want.drive !== rsp_data.drive || want.updated !== rsp_data.updated ||
                   want.auto_mode !== rsp_data.auto_mode ||
                   want.integral_value !== rsp_data.integral_value)
                  log_fault("mismatch (expected/actual)", want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            forecast_item(req_data, predicted);
            outputs_due.push_back(want_fixed ? want_row : predicted);
         end
      end
   end

   // Result side: random stall per item, or a long hold-off when asked
   initial begin : receiver
      int stall;
      do @(negedge clock); while (reset);
      forever begin
         stall = receiver_hurry ? 0 : $urandom_range(0, MAX_WAIT);
         if (rx_hold > 0) begin
            stall = rx_hold;
            rx_hold = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      req_item_type it;
      logic signed [DATA_W-1:0] a, b;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows, with the settings switched between groups
      for (int i = 0; i < PROBE_ROWS; i++) begin
         if (i == WIDE_START) begin
            settle();
            write_register(CSR_SAMPLE_PER, 16'd1);
            write_register(CSR_GAIN_KP, 16'hffff);
            write_register(CSR_TI, 16'd1);
            write_register(CSR_TD, 16'hffff);
            write_register(CSR_LIMIT_LOW, VMIN);
            write_register(CSR_LIMIT_HIGH, VMAX);
            write_register(CSR_FORWARD, 16'd0);
            csr_write_en <= 1'b0;
         end
         if (i == NARROW_START) begin
            // integral off, narrow limits, then writes that must be dropped
            settle();
            write_register(CSR_TI, 16'd0);
            write_register(CSR_FORWARD, 16'd1);
            write_register(CSR_LIMIT_LOW, -16'sd5);
            write_register(CSR_LIMIT_HIGH, 16'sd5);
            write_register(CSR_LIMIT_LOW, 16'sd5);
            write_register(CSR_LIMIT_HIGH, -16'sd5);
            write_register(CSR_SAMPLE_PER, 16'd0);
            csr_write_en <= 1'b0;
         end
         it.command = PROBE[i].command;
         it.measurement = PROBE[i].measurement;
         it.target = PROBE[i].target;
         it.manual_value = PROBE[i].manual_value;
         offer_item(it, PROBE[i].fixed, PROBE[i].want);
      end

      // Random phases, each under its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               write_register(CSR_GAIN_KP, 16'hffff);
               write_register(CSR_TI, 16'd1);
               write_register(CSR_TD, 16'hffff);
               write_register(CSR_LIMIT_LOW, VMIN);
               write_register(CSR_LIMIT_HIGH, VMAX);
               write_register(CSR_SAMPLE_PER, 16'd1);
               write_register(CSR_FORWARD, 16'd0);
            end
            1: begin
               // slowest period: ticks pile up a long interval for the next phase
               write_register(CSR_GAIN_KP, 16'd0);
               write_register(CSR_TI, 16'hffff);
               write_register(CSR_TD, 16'd0);
               write_register(CSR_LIMIT_LOW, 16'sh7ffe);
               write_register(CSR_LIMIT_HIGH, VMIN);
               write_register(CSR_SAMPLE_PER, 16'hffff);
               write_register(CSR_FORWARD, 16'd1);
            end
            default: begin
               a = pick_level();
               b = pick_level();
               write_register(CSR_GAIN_KP, ($urandom_range(0, 3) == 0) ?
                              CFG_W'($urandom) : CFG_W'($urandom_range(0, 1024)));
               write_register(CSR_TI, ($urandom_range(0, 3) == 0) ?
                              16'd0 : CFG_W'($urandom_range(1, 3000)));
               write_register(CSR_TD, ($urandom_range(0, 2) == 0) ?
                              CFG_W'($urandom) : CFG_W'($urandom_range(0, 300)));
               write_register(CSR_LIMIT_HIGH, VMAX);
               write_register(CSR_LIMIT_LOW, (a < b) ? a : b);
               write_register(CSR_LIMIT_HIGH, (a < b) ? b : a);
               write_register(CSR_SAMPLE_PER, (ph == 2) ?
                              16'd250 : CFG_W'($urandom_range(1, 4)));
               write_register(CSR_FORWARD, CFG_W'($urandom_range(0, 1)));
            end
         endcase
         csr_write_en <= 1'b0;
         phase_target = pick_level();
         sender_hurry = (ph % 3 == 1) || (ph == 3);
         receiver_hurry = (ph % 4 == 2);
         // stall the result side for a long stretch while items keep coming
         if (ph == 3) rx_hold = 600;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            offer_item(random_item(), 1'b0, '0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && outputs_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
